>>> design/gauss_seidel_solver_macros.svh
// Assertion macros used by the checker file.
`ifndef GAUSS_SEIDEL_SOLVER_MACROS_SVH
`define GAUSS_SEIDEL_SOLVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// Shared constants, codes and saturating helpers for the Gauss-Seidel solver.
// ----------------------------------------------------------------------------
package gss_pkg;

	localparam int MAX_ORDER_DEF   = 8;
	localparam int VALUE_WIDTH_DEF = 32;

	// Percent scale: 100 in Q16.16.
	localparam logic [22:0] PCT_SCALE = 23'd6553600;

	localparam logic [1:0] KIND_COEF  = 2'd0;
	localparam logic [1:0] KIND_RHS   = 2'd1;
	localparam logic [1:0] KIND_SOLVE = 2'd2;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_ITER_LIM  = 2'd1;
	localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

	localparam logic [1:0] REG_ORDER   = 2'd0;
	localparam logic [1:0] REG_TOL     = 2'd1;
	localparam logic [1:0] REG_MAX_IT  = 2'd2;

	localparam logic [3:0]  ORDER_RST  = 4'd8;
	localparam logic [22:0] TOL_RST    = 23'd65536;
	localparam logic [15:0] MAX_IT_RST = 16'd1000;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

endpackage

>>> design/gss_ram.sv
// ----------------------------------------------------------------------------
// gss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

>>> design/gss_mul.sv
// ----------------------------------------------------------------------------
// gss_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module gss_mul #(
	parameter int W = 34
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	always_ff @(posedge clk) begin
		if (en)
			p <= a * b;
	end
endmodule

>>> design/gss_div.sv
// ----------------------------------------------------------------------------
// gss_div
// Unsigned restoring divider, 64-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gss_div #(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [63:0]   quo
);
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [6:0]    cnt_q;
	logic          run_q;
	logic [DW:0]   rem_sh;
	logic          fits;

	assign rem_sh = {rem_q[DW-1:0], quo[63]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo   <= {quo[62:0], fits};
		end
	end
endmodule

>>> design/gauss_seidel_solver.sv
// Load items are written without raising busy; a solve item over n unknowns
// holds busy through the diagonal check, the sweeps and the result stream,
// paced by the shared multiplier taking one term at a time and the divider.
// The n results then follow on consecutive cycles, one per unknown.
// Reset is asynchronous, active low; coefficient and rhs storage is not cleared.
// ----------------------------------------------------------------------------
// gauss_seidel_solver
// Fixed-point Gauss-Seidel solver with an APB register port.
// ----------------------------------------------------------------------------
module gauss_seidel_solver #(
	parameter int MAX_ORDER   = gss_pkg::MAX_ORDER_DEF,
	parameter int VALUE_WIDTH = gss_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [2:0]  row,
	input  logic [2:0]  column,
	input  logic signed [31:0] value,
	output logic        strobe,
	output logic [2:0]  index,
	output logic signed [31:0] solution,
	output logic [15:0] sweeps,
	output logic [1:0]  status,
	output logic        last
);
	import gss_pkg::*;

	localparam int W    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
	localparam int MW   = (W + 2 > 24) ? W + 2 : 24;
	localparam int NMAX = (MAX_ORDER < 15) ? MAX_ORDER : 15;
	localparam int CIW  = $clog2(NMAX);
	localparam int RD   = (MAX_ORDER < 8) ? MAX_ORDER : 8;
	localparam int RIW  = (RD > 1) ? $clog2(RD) : 1;
	localparam int AW   = $clog2(MAX_ORDER * MAX_ORDER);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DG_RD = 4'd1;
	localparam logic [3:0] S_DG_CK = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_ACC   = 4'd5;
	localparam logic [3:0] S_NUM   = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_DWAIT = 4'd8;
	localparam logic [3:0] S_UPD   = 4'd9;
	localparam logic [3:0] S_T1    = 4'd10;
	localparam logic [3:0] S_T2    = 4'd11;
	localparam logic [3:0] S_T3    = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;

	logic [3:0]  state_q;
	logic [3:0]  order_q;
	logic [22:0] tol_q;
	logic [15:0] max_it_q;

	logic [3:0]     n_q;
	logic [CIW-1:0] i_q, j_q;
	logic [15:0]    sweep_q;
	logic [1:0]     status_q;
	logic           zero_q, ok_q;

	logic signed [W-1:0] est_q [NMAX];
	logic signed [W-1:0] rhs_q [RD];
	logic signed [W-1:0] x_q, xold_q, diag_q;
	logic signed [63:0]  sum_q, num_q;
	logic [W:0]          dxmag_q;
	logic [W-1:0]        xnmag_q;
	logic signed [2*MW-1:0] lhs_q;

	// Configuration port.
	logic apb_wr;
	assign apb_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			REG_ORDER:  prdata = {28'd0, order_q};
			REG_TOL:    prdata = {9'd0, tol_q};
			REG_MAX_IT: prdata = {16'd0, max_it_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q  <= ORDER_RST;
			tol_q    <= TOL_RST;
			max_it_q <= MAX_IT_RST;
		end else if (apb_wr) begin
			unique case (paddr[3:2])
				REG_ORDER:  order_q  <= pwdata[3:0];
				REG_TOL:    tol_q    <= pwdata[22:0];
				REG_MAX_IT: max_it_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	logic accept, last_i, last_j;
	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;
	assign last_i = 4'(i_q) == n_q - 4'd1;
	assign last_j = 4'(j_q) == n_q - 4'd1;

	logic [3:0]  n_eff;
	logic [15:0] limit;
	always_comb begin
		n_eff = order_q;
		if (order_q == 4'd0)
			n_eff = 4'd1;
		else if (int'(order_q) > NMAX)
			n_eff = 4'(NMAX);
		limit = (max_it_q == 16'd0) ? 16'd1 : max_it_q;
	end

	// Coefficient memory.
	logic          c_we, c_re;
	logic [AW-1:0] c_waddr, c_raddr;
	logic [W-1:0]  c_rdata;
	assign c_we    = accept && kind == KIND_COEF && int'(row) < MAX_ORDER
		&& int'(column) < MAX_ORDER;
	assign c_waddr = AW'(row) * AW'(MAX_ORDER) + AW'(column);
	assign c_re    = state_q == S_DG_RD || state_q == S_RD;
	assign c_raddr = AW'(i_q) * AW'(MAX_ORDER)
		+ ((state_q == S_DG_RD) ? AW'(i_q) : AW'(j_q));

	gss_ram #(.WIDTH(W), .DEPTH(MAX_ORDER * MAX_ORDER)) u_coef (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(value[W-1:0]),
		.re(c_re), .raddr(c_raddr), .rdata(c_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept && kind == KIND_RHS && int'(row) < RD)
			rhs_q[row[RIW-1:0]] <= value[W-1:0];
	end

	// Shared multiplier.
	logic                   mul_en;
	logic signed [MW-1:0]   mul_a, mul_b;
	logic signed [2*MW-1:0] mul_p;
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_MUL: begin
				mul_en = 1'b1;
				mul_a  = MW'($signed(c_rdata));
				mul_b  = MW'(x_q);
			end
			S_T1: begin
				mul_en = 1'b1;
				mul_a  = MW'(dxmag_q);
				mul_b  = MW'(PCT_SCALE);
			end
			S_T2: begin
				mul_en = 1'b1;
				mul_a  = MW'(tol_q);
				mul_b  = MW'(xnmag_q);
			end
			default: ;
		endcase
	end

	gss_mul #(.W(MW)) u_mul (
		.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .p(mul_p)
	);

	// Divider on magnitudes; sign is restored afterwards.
	logic        div_done;
	logic [63:0] div_quo, num_mag;
	logic [W-1:0] den_mag;
	logic        q_neg;
	assign num_mag = num_q[63] ? 64'(-num_q) : 64'(num_q);
	assign den_mag = diag_q[W-1] ? W'(-diag_q) : W'(diag_q);
	assign q_neg   = num_q[63] != diag_q[W-1];

	gss_div #(.DW(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_DIV),
		.num(num_mag), .den(den_mag), .done(div_done), .quo(div_quo)
	);

	logic signed [W-1:0] xn;
	logic signed [W:0]   dx;
	logic signed [63:0]  rhs_sel;
	always_comb begin
		if (div_quo >= 64'(1) << (W - 1))
			xn = q_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else
			xn = q_neg ? -$signed(W'(div_quo)) : $signed(W'(div_quo));
		dx = {xn[W-1], xn} - {xold_q[W-1], xold_q};
		rhs_sel = (int'(i_q) < RD) ? 64'(rhs_q[i_q[RIW-1:0]]) : '0;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_RD: x_q <= est_q[j_q];
			S_MUL: begin
				if (j_q == i_q) begin
					diag_q <= $signed(c_rdata);
					xold_q <= x_q;
				end
			end
			S_NUM: num_q <= sat_sub(rhs_sel <<< 16, sum_q);
			S_UPD: begin
				dxmag_q <= dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
				xnmag_q <= xn[W-1] ? W'(-xn) : W'(xn);
			end
			S_T2: lhs_q <= mul_p;
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= 4'd1;
			i_q      <= '0;
			j_q      <= '0;
			sweep_q  <= '0;
			status_q <= ST_CONVERGED;
			zero_q   <= 1'b0;
			ok_q     <= 1'b1;
			sum_q    <= '0;
			for (int k = 0; k < NMAX; k++)
				est_q[k] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && kind == KIND_SOLVE) begin
						for (int k = 0; k < NMAX; k++)
							est_q[k] <= '0;
						n_q     <= n_eff;
						sweep_q <= '0;
						i_q     <= '0;
						zero_q  <= 1'b0;
						state_q <= S_DG_RD;
					end
				end
				S_DG_RD: state_q <= S_DG_CK;
				S_DG_CK: begin
					if (last_i) begin
						i_q   <= '0;
						j_q   <= '0;
						sum_q <= '0;
						ok_q  <= 1'b1;
						if (zero_q || c_rdata == '0) begin
							status_q <= ST_ZERO_DIAG;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end else begin
						zero_q  <= zero_q || c_rdata == '0;
						i_q     <= i_q + 1'b1;
						state_q <= S_DG_RD;
					end
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (j_q != i_q)
						sum_q <= sat_add(sum_q, 64'(mul_p));
					if (last_j) begin
						state_q <= S_NUM;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_NUM: state_q <= S_DIV;
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done)
						state_q <= S_UPD;
				end
				S_UPD: begin
					est_q[i_q] <= xn;
					state_q    <= S_T1;
				end
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: begin
					j_q   <= '0;
					sum_q <= '0;
					if (last_i) begin
						i_q     <= '0;
						sweep_q <= sweep_q + 16'd1;
						ok_q    <= 1'b1;
						if (ok_q && !(lhs_q > mul_p)) begin
							status_q <= ST_CONVERGED;
							state_q  <= S_OUT;
						end else if (sweep_q + 16'd1 >= limit) begin
							status_q <= ST_ITER_LIM;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end else begin
						ok_q    <= ok_q && !(lhs_q > mul_p);
						i_q     <= i_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					j_q <= j_q + 1'b1;
					if (last_j) begin
						j_q     <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Results stream straight from the estimate registers.
	assign strobe   = state_q == S_OUT;
	assign index    = 3'(j_q);
	assign solution = 32'(est_q[j_q]);
	assign sweeps   = sweep_q;
	assign status   = status_q;
	assign last     = strobe && last_j;
endmodule

>>> design/gss_chk.sv
// ----------------------------------------------------------------------------
// gss_chk
// Port-level checks on the solver's result stream.
// ----------------------------------------------------------------------------
`include "gauss_seidel_solver_macros.svh"

module gss_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        strobe,
	input logic [2:0]  index,
	input logic [31:0] solution,
	input logic [15:0] sweeps,
	input logic [1:0]  status,
	input logic        last
);
	import gss_pkg::*;

	`GSS_ASSERT_SAME(a_out_busy, strobe, busy, "result outside a solve")
	`GSS_ASSERT_NEXT(a_burst, strobe && !last, strobe && index == 3'($past(index) + 3'd1), "result burst broken")
	`GSS_ASSERT_NEXT(a_run_info, strobe && !last, status == $past(status) && sweeps == $past(sweeps), "run info changed in burst")
	`GSS_ASSERT_NEXT(a_done, strobe && last, !busy && !strobe, "block busy after final result")
	`GSS_ASSERT_SAME(a_zdiag, strobe && status == ST_ZERO_DIAG, solution == '0 && sweeps == '0, "zero diagonal run not empty")
endmodule

bind gauss_seidel_solver gss_chk u_gss_chk (
	.clk(clk), .arst_n(arst_n), .busy(busy), .strobe(strobe), .index(index),
	.solution(solution), .sweeps(sweeps), .status(status), .last(last)
);
